// File: rtl/core/luhn_pkg.sv
`timescale 1ns / 1ps

package luhn_pkg;

  localparam int DigitW = 4;
  localparam int CountW = 5;
  localparam int SumW   = 4;

  localparam logic [CountW-1:0] LenSat = CountW'(17);

  localparam logic [SumW:0]     Radix     = (SumW+1)'(10);
  localparam logic [SumW:0]     FoldDbl   = (SumW+1)'(9);

  localparam logic [DigitW-1:0] PrefixAmex   = DigitW'(3);
  localparam logic [DigitW-1:0] PrefixVisa   = DigitW'(4);
  localparam logic [DigitW-1:0] PrefixMaster = DigitW'(5);
  localparam logic [DigitW-1:0] PrefixDisc   = DigitW'(6);

  localparam logic [CountW-1:0] Len13 = CountW'(13);
  localparam logic [CountW-1:0] Len14 = CountW'(14);
  localparam logic [CountW-1:0] Len15 = CountW'(15);
  localparam logic [CountW-1:0] Len16 = CountW'(16);

  // one digit handed from the input register to the accumulator
  typedef struct packed {
    logic              en;
    logic [DigitW-1:0] digit;
    logic              last;
  } step_t;

  // digit value mod 10, for a digit that is not doubled
  function automatic logic [SumW-1:0] plain_term(input logic [DigitW-1:0] d);
    logic [SumW:0] t;
    t = {1'b0, d};
    if (t >= Radix) begin
      t = t - Radix;
    end
    return t[SumW-1:0];
  endfunction

  // 2d, folded by 9 when it reaches ten, then mod 10
  // (a folded value can reach 21 for wide digits, so up to two subtractions)
  function automatic logic [SumW-1:0] doubled_term(input logic [DigitW-1:0] d);
    logic [SumW:0] t;
    t = {d, 1'b0};
    if (t >= Radix) begin
      t = t - FoldDbl;
    end
    if (t >= Radix) begin
      t = t - Radix;
    end
    if (t >= Radix) begin
      t = t - Radix;
    end
    return t[SumW-1:0];
  endfunction

  function automatic logic [SumW-1:0] add_mod10(input logic [SumW-1:0] a,
                                                input logic [SumW-1:0] b);
    logic [SumW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= Radix) begin
      s = s - Radix;
    end
    return s[SumW-1:0];
  endfunction

  function automatic logic pair_allowed(input logic [DigitW-1:0] first,
                                        input logic [CountW-1:0] len);
    logic ok;
    ok = 1'b0;
    if (first == PrefixAmex) begin
      ok = (len == Len14) || (len == Len15);
    end else if (first == PrefixVisa) begin
      ok = (len == Len13) || (len == Len16);
    end else if (first == PrefixMaster || first == PrefixDisc) begin
      ok = (len == Len16);
    end
    return ok;
  endfunction

endpackage

// File: rtl/core/luhn_digit_if.sv
`timescale 1ns / 1ps

interface luhn_digit_if
  import luhn_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DigitW-1:0] digit;
  logic              last;

  modport source (output valid, output digit, output last, input ready);
  modport sink   (input valid, input digit, input last, output ready);
endinterface

// File: rtl/core/luhn_result_if.sv
`timescale 1ns / 1ps

interface luhn_result_if;
  logic valid;
  logic ready;
  logic valid_res;

  modport source (output valid, output valid_res, input ready);
  modport sink   (input valid, input valid_res, output ready);
endinterface

// File: rtl/core/luhn_accum.sv
`timescale 1ns / 1ps

module luhn_accum
  import luhn_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  step_t step,
  output logic  ok
);

  logic [SumW-1:0]   sum_even_doubled, sum_even_doubled_next;
  logic [SumW-1:0]   sum_odd_doubled, sum_odd_doubled_next;
  logic [CountW-1:0] digit_count, digit_count_next;
  logic [DigitW-1:0] first_digit, first_digit_next;

  logic            pos_odd;
  logic [SumW-1:0] plain, dbl, total;

  always_comb begin
    pos_odd = digit_count[0];
    plain   = plain_term(step.digit);
    dbl     = doubled_term(step.digit);

    first_digit_next = (digit_count == '0) ? step.digit : first_digit;

    if (pos_odd) begin
      sum_odd_doubled_next  = add_mod10(sum_odd_doubled, dbl);
      sum_even_doubled_next = add_mod10(sum_even_doubled, plain);
    end else begin
      sum_even_doubled_next = add_mod10(sum_even_doubled, dbl);
      sum_odd_doubled_next  = add_mod10(sum_odd_doubled, plain);
    end

    digit_count_next = (digit_count < LenSat) ? digit_count + CountW'(1) : digit_count;

    // check digit is never doubled: take the sum where its parity is plain
    total = pos_odd ? sum_even_doubled_next : sum_odd_doubled_next;
    ok    = (total == '0) && pair_allowed(first_digit_next, digit_count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_even_doubled <= '0;
      sum_odd_doubled  <= '0;
      digit_count      <= '0;
      first_digit      <= '0;
    end else if (step.en) begin
      if (step.last) begin
        sum_even_doubled <= '0;
        sum_odd_doubled  <= '0;
        digit_count      <= '0;
        first_digit      <= '0;
      end else begin
        sum_even_doubled <= sum_even_doubled_next;
        sum_odd_doubled  <= sum_odd_doubled_next;
        digit_count      <= digit_count_next;
        first_digit      <= first_digit_next;
      end
    end
  end

endmodule

// File: rtl/core/luhn_card_number_validator_unit.sv
`timescale 1ns / 1ps

// channel   dir  payload              notes
// -------   ---  -------------------  -------------------------------------
// digits    in   digit[3:0], last     one decimal digit per request, msd first
// results   out  valid_res            one request per number, on its last digit
//
// one digit accepted per cycle unless a last digit waits on a full result
// register; the accumulator update is a single mod-10 add between the input
// register and the running-sum registers; a result is registered as its last
// digit leaves the input register; rst (synchronous) empties both registers
// and clears the running sums; only a held last digit waits on a full result
// register; other digits keep flowing while a result is stalled

module luhn_card_number_validator_unit
  import luhn_pkg::*;
(
  input logic          clk,
  input logic          rst,
  luhn_digit_if.sink   digits,
  luhn_result_if.source results
);

  // input register
  logic              in_valid;
  logic [DigitW-1:0] in_digit;
  logic              in_last;

  // result register
  logic res_valid;
  logic res_value;

  logic  out_free;
  logic  advance;
  logic  ok;
  step_t step;

  // a digit leaves the input register unless it is a last digit
  // facing a result that has not been taken yet
  assign out_free     = !res_valid || results.ready;
  assign advance      = in_valid && (!in_last || out_free);
  assign digits.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (digits.ready) begin
      in_valid <= digits.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (digits.valid && digits.ready) begin
      in_digit <= digits.digit;
      in_last  <= digits.last;
    end
  end

  always_comb begin
    step.en    = advance;
    step.digit = in_digit;
    step.last  = in_last;
  end

  // running sums, length and prefix; ok is the verdict for a last digit
  luhn_accum u_accum (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .ok   (ok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && in_last) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      res_value <= ok;
    end
  end

  assign results.valid     = res_valid;
  assign results.valid_res = res_value;

endmodule

// File: rtl/core/luhn_checker.sv
`timescale 1ns / 1ps

module luhn_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input logic out_res
);

  // numbers whose last digit went in but whose result is not yet delivered
  logic [1:0] pending;
  logic       last_in;
  logic       res_out;

  assign last_in = in_valid && in_ready && in_last;
  assign res_out = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (last_in && !res_out) begin
      pending <= pending + 2'd1;
    end else if (res_out && !last_in) begin
      pending <= pending - 2'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_res))
    else $error("stalled result changed or dropped");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("result without a pending number");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more numbers pending than the block can hold");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty result register");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind luhn_card_number_validator_unit luhn_checker u_luhn_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (digits.valid),
  .in_ready  (digits.ready),
  .in_last   (digits.last),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_res   (results.valid_res)
);

// File: test/tb_luhn_card_number_validator_unit.sv
`timescale 1ns / 1ps

module tb_luhn_card_number_validator_unit;
  import luhn_pkg::*;

  // run limits
  localparam int CycleLimit = 400000;
  localparam int DigitTarget = 1250;
  localparam int QuietTail = 200;   // digits at the end sent with no gaps
  localparam int HoldCycles = 300;  // long stall on the results side
  localparam int DrainCycles = 8;   // idle wait after the last result is taken

  logic clk;
  logic rst;

  luhn_digit_if  digits_bus ();
  luhn_result_if results_bus ();

  luhn_card_number_validator_unit dut (
    .clk     (clk),
    .rst     (rst),
    .digits  (digits_bus),
    .results (results_bus)
  );

  // running luhn state of the number in flight plus the queue of verdicts
  // that the block still owes
  class luhn_scoreboard;
    logic [SumW-1:0]   sum_even_dbl;
    logic [SumW-1:0]   sum_odd_dbl;
    logic [CountW-1:0] length;
    logic [DigitW-1:0] lead;
    logic              verdicts[$];
    int                errors;

    function new();
      restart();
      errors = 0;
    endfunction

    function void restart();
      sum_even_dbl = '0;
      sum_odd_dbl  = '0;
      length       = '0;
      lead         = '0;
    endfunction

    function logic brand_ok(logic [DigitW-1:0] first, logic [CountW-1:0] len);
      case (first)
        PrefixAmex:   return (len == Len14) || (len == Len15);
        PrefixVisa:   return (len == Len13) || (len == Len16);
        PrefixMaster,
        PrefixDisc:   return len == Len16;
        default:      return 1'b0;
      endcase
    endfunction

    function int pending();
      return verdicts.size();
    endfunction

    // one accepted digit request
    function void note_digit(logic [DigitW-1:0] d, logic fin);
      int               dbl;
      int               plain;
      logic             odd_pos;
      logic [SumW-1:0]  total;
      dbl = 2 * int'(d);
      if (dbl >= 10) begin
        dbl = dbl - 9;
      end
      dbl     = dbl % 10;
      plain   = int'(d) % 10;
      odd_pos = length[0];
      if (length == 0) begin
        lead = d;
      end
      if (odd_pos) begin
        sum_odd_dbl  = SumW'((int'(sum_odd_dbl) + dbl) % 10);
        sum_even_dbl = SumW'((int'(sum_even_dbl) + plain) % 10);
      end else begin
        sum_even_dbl = SumW'((int'(sum_even_dbl) + dbl) % 10);
        sum_odd_dbl  = SumW'((int'(sum_odd_dbl) + plain) % 10);
      end
      if (length < LenSat) begin
        length = length + 1'b1;
      end
      if (fin) begin
        // check digit stays plain, so take the sum that doubles the other parity
        total = odd_pos ? sum_even_dbl : sum_odd_dbl;
        verdicts.push_back((total == 0) && brand_ok(lead, length));
        restart();
      end
    endfunction

    // one accepted result request
    function void check_result(logic got);
      logic want;
      if (verdicts.size() == 0) begin
        $display("%0t: valid_res expected none actual %b", $time, got);
        errors++;
      end else begin
        want = verdicts.pop_front();
        if (got !== want) begin
          $display("%0t: valid_res expected %b actual %b", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  luhn_scoreboard sb = new();

  bit src_gaps;
  bit sink_gaps;
  bit hold_results;
  int digits_sent;
  int cycles;

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("[luhn_card_number_validator_unit] ERROR");
      $finish;
    end
  end

  // observe both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (digits_bus.valid && digits_bus.ready) begin
        sb.note_digit(digits_bus.digit, digits_bus.last);
      end
      if (results_bus.valid && results_bus.ready) begin
        sb.check_result(results_bus.valid_res);
      end
    end
  end

  // results side: random stall bursts, one long hold on request from the
  // main thread so the block backs up and stalls its digit input
  initial begin
    results_bus.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_results) begin
        results_bus.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_results = 1'b0;
      end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
        results_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end else begin
        results_bus.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // offer one digit request, starting and ending at a falling edge
  task automatic send_digit(input logic [DigitW-1:0] d, input logic fin);
    if (src_gaps && $urandom_range(0, 7) == 0) begin
      digits_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    digits_bus.valid <= 1'b1;
    digits_bus.digit <= d;
    digits_bus.last  <= fin;
    do @(posedge clk); while (!digits_bus.ready);
    digits_sent++;
    @(negedge clk);
  endtask

  // one whole number; with fix_check the last digit is chosen so the
  // luhn total comes out to zero
  task automatic send_card(input int first, input int len, input int digit_max,
                           input bit fix_check);
    logic [DigitW-1:0] num[$];
    int                s;
    int                t;
    num.push_back(DigitW'(first));
    for (int i = 1; i < len; i++) begin
      num.push_back(DigitW'($urandom_range(0, digit_max)));
    end
    if (fix_check && len > 1) begin
      s = 0;
      for (int i = 0; i < len - 1; i++) begin
        t = int'(num[i]);
        if ((i % 2) != ((len - 1) % 2)) begin
          t = 2 * t;
          if (t > 9) begin
            t = t - 9;
          end
        end
        s += t;
      end
      num[len-1] = DigitW'((10 - (s % 10)) % 10);
    end
    foreach (num[i]) begin
      send_digit(num[i], i == len - 1);
    end
  endtask

  initial begin
    int pick;
    int first;
    int len;
    rst              = 1'b1;
    digits_bus.valid = 1'b0;
    digits_bus.digit = '0;
    digits_bus.last  = 1'b0;
    src_gaps     = 1'b0;
    sink_gaps    = 1'b0;
    hold_results = 1'b0;
    digits_sent  = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: single-digit numbers, digit above nine on its own,
    // a good 13-digit visa, and a short number of wide digits
    send_digit(DigitW'(0), 1'b1);
    send_digit(DigitW'(15), 1'b1);
    send_card(4, 13, 9, 1'b1);
    send_digit(DigitW'(6), 1'b0);
    send_digit(DigitW'(10), 1'b0);
    send_digit(DigitW'(12), 1'b0);
    send_digit(DigitW'(15), 1'b1);

    // long results stall while digits keep coming
    src_gaps     = 1'b1;
    sink_gaps    = 1'b1;
    hold_results = 1'b1;

    while (digits_sent < DigitTarget) begin
      if (digits_sent >= DigitTarget - QuietTail) begin
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
      end
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        // well-formed brand and length, mostly with a passing check digit
        first = $urandom_range(3, 6);
        case (first)
          3:       len = 14 + $urandom_range(0, 1);
          4:       len = ($urandom_range(0, 1) == 0) ? 13 : 16;
          default: len = 16;
        endcase
        send_card(first, len, 9, $urandom_range(0, 3) != 0);
      end else if (pick == 6) begin
        // right brand, length near the valid ones (12 to 17)
        send_card($urandom_range(3, 6), $urandom_range(12, 17), 9, 1'b1);
      end else if (pick == 7) begin
        // noise: any lead, any digit value
        send_card($urandom_range(0, 15), $urandom_range(1, 20), 15,
                  1'($urandom_range(0, 1)));
      end else if (pick == 8) begin
        // at or past the length saturation
        send_card($urandom_range(3, 6), $urandom_range(17, 24), 9, 1'b1);
      end else begin
        send_card($urandom_range(0, 15), $urandom_range(1, 3), 15,
                  1'($urandom_range(0, 1)));
      end
    end

    digits_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (sb.errors == 0) begin
      $display("[luhn_card_number_validator_unit] OK");
    end else begin
      $display("[luhn_card_number_validator_unit] ERROR");
    end
    $finish;
  end

endmodule
